// ----- src/vision_target_approach_steering_assert.svh -----
// Assertion macros used by the checker module of the approach steering block
`ifndef VISION_TARGET_APPROACH_STEERING_ASSERT_SVH
`define VISION_TARGET_APPROACH_STEERING_ASSERT_SVH

// same-cycle implication, off during reset
`define VTAS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define VTAS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// what must hold in the cycle after reset is sampled low
`define VTAS_ASSERT_RST(label, cons, msg) \
  label: assert property (@(posedge clk) !rst_n |=> (cons)) \
    else $error(msg);

`endif

// ----- src/vtas_pkg.sv -----
// Shared constants, codes and controller/datapath types of the approach steering block
`timescale 1ns / 1ps

package vtas_pkg;

  // field widths
  localparam int DATA_W     = 16;
  localparam int TIME_W     = 32;
  localparam int MS_W       = 16;
  localparam int KIND_W     = 2;
  localparam int ACT_W      = 2;
  localparam int PHASE_W    = 2;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam int FRAC_BITS_DEF = 14;

  // word kinds
  localparam logic [KIND_W-1:0] KIND_START = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TICK  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END   = 2'd2;

  // drive actions
  localparam logic [ACT_W-1:0] ACT_NONE  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_STOP  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DRIVE = 2'd2;

  // approach phases
  localparam logic [PHASE_W-1:0] PH_IDLE  = 2'd0;
  localparam logic [PHASE_W-1:0] PH_MOVE  = 2'd1;
  localparam logic [PHASE_W-1:0] PH_COAST = 2'd2;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_TAPE  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_LOST  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_COAST = 2'd2;

  // configuration reset values
  localparam logic [MS_W-1:0] LOST_TIMEOUT_RST = 16'd1000;
  localparam logic [MS_W-1:0] COAST_TIME_RST   = 16'd500;

  // controller to datapath
  typedef struct packed {
    logic load_in;   // capture the input word
    logic fuse;      // fuse cameras, decide, update state, wheel product
    logic mul_x;     // proportional product
    logic mul_gain;  // wheel times |x| product
    logic calc;      // combine, clamp and form drive values
    logic load_out;  // move pending result into the output register
  } vtas_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic steer;     // tick needs the steering products
  } vtas_sts_t;

endpackage

// ----- src/vtas_in_if.sv -----
// Input channel: start, tick or stop word with camera and wheel data
`timescale 1ns / 1ps

interface vtas_in_if;
  import vtas_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic [TIME_W-1:0]        now_ms;
  logic                     left_seen;
  logic                     right_seen;
  logic signed [DATA_W-1:0] left_x;
  logic signed [DATA_W-1:0] left_y;
  logic signed [DATA_W-1:0] right_x;
  logic signed [DATA_W-1:0] right_y;
  logic signed [DATA_W-1:0] wheel_speed;

  modport source (
    output valid, kind, now_ms, left_seen, right_seen,
    output left_x, left_y, right_x, right_y, wheel_speed,
    input  ready
  );
  modport sink (
    input  valid, kind, now_ms, left_seen, right_seen,
    input  left_x, left_y, right_x, right_y, wheel_speed,
    output ready
  );
endinterface

// ----- src/vtas_out_if.sv -----
// Result channel: drive action, motor commands and status flags
`timescale 1ns / 1ps

interface vtas_out_if;
  import vtas_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [ACT_W-1:0]         drive_action;
  logic signed [DATA_W-1:0] left_drive;
  logic signed [DATA_W-1:0] right_drive;
  logic                     lights_on;
  logic                     done_res;

  modport source (
    output valid, drive_action, left_drive, right_drive, lights_on, done_res,
    input  ready
  );
  modport sink (
    input  valid, drive_action, left_drive, right_drive, lights_on, done_res,
    output ready
  );
endinterface

// ----- src/vtas_cfg_if.sv -----
// Configuration write channel: register index and data
`timescale 1ns / 1ps

interface vtas_cfg_if;
  import vtas_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

// ----- src/vision_target_approach_steering.sv -----
// Top level of the vision target approach steering block
`timescale 1ns / 1ps

// Vision target approach steering. Each input word is a start, a control tick
// or a stop; each gives exactly one result word. A start, a stop, or a tick that
// stops, coasts or finds the target close enough goes from fuse to emit, which
// loads the output register; a steering tick passes mul1, mul2 and calc between,
// as its three products (0.2*wheel, 0.4*x, then 0.2*wheel times |x|) go one after
// the other through the single shared multiplier before the clamp stage. The next
// word is accepted in the cycle its predecessor's result is loaded, so a result
// waiting on a stalled output does not hold back the input until the following
// one is ready. Configuration writes are taken at any time (ready is always high)
// and belong in idle stretches. Values are signed with FRAC_BITS fraction bits.
module vision_target_approach_steering #(
  parameter int FRAC_BITS = vtas_pkg::FRAC_BITS_DEF
) (
  input logic     clk,
  input logic     rst_n,
  vtas_in_if.sink   in_ch,
  vtas_out_if.source out_ch,
  vtas_cfg_if.sink  cfg_ch
);
  import vtas_pkg::*;

  vtas_cmd_t cmd;
  vtas_sts_t sts;

  assign cfg_ch.ready = 1'b1;

  // step sequencer
  vtas_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // arithmetic and state
  vtas_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_we           (cfg_ch.valid),
    .cfg_addr         (cfg_ch.addr),
    .cfg_data         (cfg_ch.data),
    .in_kind          (in_ch.kind),
    .in_now_ms        (in_ch.now_ms),
    .in_left_seen     (in_ch.left_seen),
    .in_right_seen    (in_ch.right_seen),
    .in_left_x        (in_ch.left_x),
    .in_left_y        (in_ch.left_y),
    .in_right_x       (in_ch.right_x),
    .in_right_y       (in_ch.right_y),
    .in_wheel_speed   (in_ch.wheel_speed),
    .out_drive_action (out_ch.drive_action),
    .out_left_drive   (out_ch.left_drive),
    .out_right_drive  (out_ch.right_drive),
    .out_lights_on    (out_ch.lights_on),
    .out_done_res     (out_ch.done_res)
  );

endmodule

// ----- src/vtas_ctrl.sv -----
// Sequencing controller: input/output handshakes and datapath step commands
`timescale 1ns / 1ps

module vtas_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  vtas_pkg::vtas_sts_t sts,
  output vtas_pkg::vtas_cmd_t cmd
);
  import vtas_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_FUSE = 6'b000010,
    ST_MUL1 = 6'b000100,
    ST_MUL2 = 6'b001000,
    ST_CALC = 6'b010000,
    ST_EMIT = 6'b100000
  } vtas_state_t;

  vtas_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_free;
  logic        take_in;

  // output register can take a word this cycle
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE) || ((state_r == ST_EMIT) && out_free);
  assign take_in  = in_valid && in_ready;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.load_in = take_in;
    case (state_r)
      ST_IDLE: begin
        if (take_in) state_nxt = ST_FUSE;
      end
      ST_FUSE: begin
        cmd.fuse  = 1'b1;
        state_nxt = sts.steer ? ST_MUL1 : ST_EMIT;
      end
      ST_MUL1: begin
        cmd.mul_x = 1'b1;
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul_gain = 1'b1;
        state_nxt    = ST_CALC;
      end
      ST_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = take_in ? ST_FUSE : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out)   out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- src/vtas_dp.sv -----
// Datapath: camera fusion, phase state, shared multiplier, clamp and result registers
`timescale 1ns / 1ps

module vtas_dp #(
  parameter int FRAC_BITS = vtas_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  vtas_pkg::vtas_cmd_t               cmd,
  output vtas_pkg::vtas_sts_t               sts,
  // configuration writes
  input  logic                              cfg_we,
  input  logic [vtas_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [vtas_pkg::CFG_DATA_W-1:0]   cfg_data,
  // input word
  input  logic [vtas_pkg::KIND_W-1:0]       in_kind,
  input  logic [vtas_pkg::TIME_W-1:0]       in_now_ms,
  input  logic                              in_left_seen,
  input  logic                              in_right_seen,
  input  logic signed [vtas_pkg::DATA_W-1:0] in_left_x,
  input  logic signed [vtas_pkg::DATA_W-1:0] in_left_y,
  input  logic signed [vtas_pkg::DATA_W-1:0] in_right_x,
  input  logic signed [vtas_pkg::DATA_W-1:0] in_right_y,
  input  logic signed [vtas_pkg::DATA_W-1:0] in_wheel_speed,
  // result word
  output logic [vtas_pkg::ACT_W-1:0]        out_drive_action,
  output logic signed [vtas_pkg::DATA_W-1:0] out_left_drive,
  output logic signed [vtas_pkg::DATA_W-1:0] out_right_drive,
  output logic                              out_lights_on,
  output logic                              out_done_res
);
  import vtas_pkg::*;

  // working widths: positions and constants, products, steering sums
  localparam int W  = (FRAC_BITS + 3 > 19) ? FRAC_BITS + 3 : 19;
  localparam int PW = 2 * W;
  localparam int VW = 24;

  // constants rounded to nearest at FRAC_BITS
  localparam int KOffset = ((6 << FRAC_BITS) + 50) / 100;
  localparam int KFwd    = ((2 << FRAC_BITS) + 5) / 10;
  localparam int KCube   = ((85 << FRAC_BITS) + 50) / 100;
  localparam int KHalf   = ((5 << FRAC_BITS) + 5) / 10;
  localparam int KSens   = ((4 << FRAC_BITS) + 5) / 10;
  localparam int KDSens  = ((2 << FRAC_BITS) + 5) / 10;
  localparam int KMax    = ((17 << FRAC_BITS) + 50) / 100;

  localparam logic signed [W-1:0]  KOffsetW = W'(KOffset);
  localparam logic signed [W-1:0]  KCubeW   = W'(KCube);
  localparam logic signed [W-1:0]  KHalfW   = W'(KHalf);
  localparam logic signed [W-1:0]  KSensW   = W'(KSens);
  localparam logic signed [W-1:0]  KDSensW  = W'(KDSens);
  localparam logic signed [VW-1:0] KFwdV    = VW'(KFwd);
  localparam logic signed [VW-1:0] KMaxV    = VW'(KMax);
  localparam logic signed [VW-1:0] SatHi    = VW'(32767);
  localparam logic signed [VW-1:0] SatLo    = VW'(-32768);

  function automatic logic signed [DATA_W-1:0] sat16(input logic signed [VW-1:0] v);
    logic signed [VW-1:0] c;
    c = v;
    if (v > SatHi) c = SatHi;
    if (v < SatLo) c = SatLo;
    return c[DATA_W-1:0];
  endfunction

  // configuration registers
  logic            tape_r;
  logic [MS_W-1:0] lost_to_r;
  logic [MS_W-1:0] coast_to_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tape_r     <= 1'b0;
      lost_to_r  <= LOST_TIMEOUT_RST;
      coast_to_r <= COAST_TIME_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_TAPE:  tape_r     <= cfg_data[0];
        CFG_LOST:  lost_to_r  <= cfg_data[MS_W-1:0];
        CFG_COAST: coast_to_r <= cfg_data[MS_W-1:0];
        default: ;
      endcase
    end
  end

  // captured input word
  logic [KIND_W-1:0]        kind_r;
  logic [TIME_W-1:0]        now_r;
  logic                     sl_r, sr_r;
  logic signed [DATA_W-1:0] lx_r, ly_r, rx_r, ry_r, wheel_r;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      kind_r  <= in_kind;
      now_r   <= in_now_ms;
      sl_r    <= in_left_seen;
      sr_r    <= in_right_seen;
      lx_r    <= in_left_x;
      ly_r    <= in_left_y;
      rx_r    <= in_right_x;
      ry_r    <= in_right_y;
      wheel_r <= in_wheel_speed;
    end
  end

  // camera fusion
  logic signed [W-1:0] lx_w, ly_w, rx_w, ry_w;
  logic signed [W-1:0] x_f, y_f, dx, adx;

  assign lx_w = W'(lx_r);
  assign ly_w = W'(ly_r);
  assign rx_w = W'(rx_r);
  assign ry_w = W'(ry_r);
  assign dx   = rx_w - lx_w;
  assign adx  = dx[W-1] ? -dx : dx;

  always_comb begin
    if (sl_r && sr_r) begin
      x_f = (lx_w + rx_w) >>> 1;
      y_f = (ly_w + ry_w) >>> 1;
    end else if (sl_r) begin
      x_f = lx_w - KOffsetW;
      y_f = ly_w;
    end else begin
      x_f = rx_w + KOffsetW;
      y_f = ry_w;
    end
  end

  // phase state
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [TIME_W-1:0]  start_r, start_nxt;
  logic               fin_r, fin_nxt;
  logic               lights_r, lights_nxt;
  logic [TIME_W-1:0]  elapsed;
  logic               lost_exp, coast_exp, close;
  logic [ACT_W-1:0]   act;
  logic               drv_close;
  logic               steer;

  assign elapsed   = now_r - start_r;
  assign lost_exp  = elapsed > TIME_W'(lost_to_r);
  assign coast_exp = elapsed > TIME_W'(coast_to_r);

  // close enough to hand over to coasting
  always_comb begin
    if (!tape_r)            close = y_f < -KCubeW;
    else if (sl_r && sr_r)  close = adx > KHalfW;
    else                    close = y_f < -KHalfW;
  end

  // per-word decision
  always_comb begin
    phase_nxt  = phase_r;
    start_nxt  = start_r;
    fin_nxt    = fin_r;
    lights_nxt = lights_r;
    act        = ACT_NONE;
    drv_close  = 1'b0;
    steer      = 1'b0;
    case (kind_r)
      KIND_START: begin
        phase_nxt = PH_MOVE;
        start_nxt = now_r;
        fin_nxt   = 1'b0;
        if (tape_r) lights_nxt = 1'b1;
        act = ACT_STOP;
      end
      KIND_END: begin
        lights_nxt = 1'b0;
        act        = ACT_STOP;
      end
      KIND_TICK: begin
        if ((phase_r == PH_IDLE) || (!sl_r && !sr_r)) begin
          if (lost_exp) fin_nxt = 1'b1;
          act = ACT_STOP;
        end else if ((phase_r == PH_COAST) && coast_exp) begin
          phase_nxt = PH_IDLE;
          start_nxt = now_r;
          fin_nxt   = 1'b1;
          act       = ACT_STOP;
        end else if (phase_r != PH_MOVE) begin
          act = ACT_NONE;
        end else if (close) begin
          phase_nxt = PH_COAST;
          start_nxt = now_r;
          act       = ACT_DRIVE;
          drv_close = 1'b1;
        end else begin
          act   = ACT_DRIVE;
          steer = 1'b1;
        end
      end
      default: act = ACT_NONE;
    endcase
  end

  assign sts.steer = steer;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      start_r  <= '0;
      fin_r    <= 1'b0;
      lights_r <= 1'b0;
    end else if (cmd.fuse) begin
      phase_r  <= phase_nxt;
      start_r  <= start_nxt;
      fin_r    <= fin_nxt;
      lights_r <= lights_nxt;
    end
  end

  // shared multiplier, floor shift by FRAC_BITS
  logic signed [VW-1:0] w_r, v1_r, v2_r;
  logic signed [W-1:0]  x_r, ax;
  logic signed [W-1:0]  mul_a, mul_b;
  logic signed [PW-1:0] prod, prod_sh;
  logic signed [VW-1:0] mul_q;

  assign ax = x_r[W-1] ? -x_r : x_r;

  always_comb begin
    if (cmd.fuse) begin
      mul_a = W'(wheel_r);
      mul_b = KDSensW;
    end else if (cmd.mul_x) begin
      mul_a = x_r;
      mul_b = KSensW;
    end else begin
      mul_a = W'(w_r);
      mul_b = ax;
    end
  end

  assign prod    = PW'(mul_a) * PW'(mul_b);
  assign prod_sh = prod >>> FRAC_BITS;
  assign mul_q   = prod_sh[VW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.fuse) begin
      x_r <= x_f;
      w_r <= mul_q;
    end
    if (cmd.mul_x)    v1_r <= mul_q;
    if (cmd.mul_gain) v2_r <= mul_q;
  end

  // steering combine: sign guard, clamp, differential drive
  logic signed [VW-1:0] vb, vb_g, vb_c;

  always_comb begin
    vb   = v1_r + v2_r;
    vb_g = vb;
    if (((v1_r > 0) && (vb < 0)) || ((v1_r < 0) && (vb > 0))) vb_g = '0;
    vb_c = vb_g;
    if (vb_g > KMaxV)       vb_c = KMaxV;
    else if (vb_g < -KMaxV) vb_c = -KMaxV;
  end

  // pending result
  logic [ACT_W-1:0]         res_act_r;
  logic signed [DATA_W-1:0] res_left_r, res_right_r;
  logic                     res_lights_r, res_done_r;

  always_ff @(posedge clk) begin
    if (cmd.fuse) begin
      res_act_r    <= act;
      res_left_r   <= drv_close ? sat16(-KFwdV) : '0;
      res_right_r  <= drv_close ? sat16(-KFwdV) : '0;
      res_lights_r <= lights_nxt;
      res_done_r   <= fin_nxt;
    end else if (cmd.calc) begin
      res_act_r   <= ACT_DRIVE;
      res_left_r  <= sat16(-KFwdV - vb_c);
      res_right_r <= sat16(-KFwdV + vb_c);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_drive_action <= res_act_r;
      out_left_drive   <= res_left_r;
      out_right_drive  <= res_right_r;
      out_lights_on    <= res_lights_r;
      out_done_res     <= res_done_r;
    end
  end

endmodule

// ----- src/vtas_checker.sv -----
// Port-level assertions of the approach steering block and their bind
`timescale 1ns / 1ps
`include "vision_target_approach_steering_assert.svh"

module vtas_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [vtas_pkg::ACT_W-1:0]        out_action,
  input logic signed [vtas_pkg::DATA_W-1:0] out_left,
  input logic signed [vtas_pkg::DATA_W-1:0] out_right,
  input logic                              out_lights,
  input logic                              out_done
);
  import vtas_pkg::*;

  // a stalled result word holds
  `VTAS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_action) && $stable(out_left) && $stable(out_right) && $stable(out_lights) && $stable(out_done), "result word changed while stalled")

  // motor commands are zero unless driving
  `VTAS_ASSERT_IMP(a_drive_zero, out_valid && (out_action != ACT_DRIVE), (out_left == '0) && (out_right == '0), "nonzero drive without drive action")

  // steering never outweighs the forward term
  `VTAS_ASSERT_IMP(a_drive_fwd, out_valid && (out_action == ACT_DRIVE), out_left[DATA_W-1] && out_right[DATA_W-1], "drive command not toward the target")

  // no result word straight out of reset
  `VTAS_ASSERT_RST(a_rst_empty, !out_valid, "result valid after reset")

endmodule

bind vision_target_approach_steering vtas_checker u_vtas_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_action (out_ch.drive_action),
  .out_left   (out_ch.left_drive),
  .out_right  (out_ch.right_drive),
  .out_lights (out_ch.lights_on),
  .out_done   (out_ch.done_res)
);

// ----- test/tb_vision_target_approach_steering.sv -----
// Testbench for the approach steering block: directed table and random words, scored against a predictor
`timescale 1ns / 1ps

module tb_vision_target_approach_steering;
  import vtas_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;

  // Q2.14 steering constants, rounded to nearest
  localparam longint C_CAM_SHIFT = ((longint'(6) << FRAC) + 50) / 100;
  localparam longint C_CREEP     = ((longint'(2) << FRAC) + 5) / 10;
  localparam longint C_CUBE_NEAR = ((longint'(85) << FRAC) + 50) / 100;
  localparam longint C_HALF      = ((longint'(5) << FRAC) + 5) / 10;
  localparam longint C_GAIN_X    = ((longint'(4) << FRAC) + 5) / 10;
  localparam longint C_GAIN_W    = ((longint'(2) << FRAC) + 5) / 10;
  localparam longint C_VB_MAX    = ((longint'(17) << FRAC) + 50) / 100;

  // unused kind code, ignored by the block
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

  localparam int SETTLE_CYCLES = 10;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int N_PHASES      = 10;
  localparam int PHASE_WORDS   = 75;

  typedef struct {
    logic [KIND_W-1:0]        kind;
    logic [TIME_W-1:0]        now_ms;
    logic                     left_seen;
    logic                     right_seen;
    logic signed [DATA_W-1:0] left_x;
    logic signed [DATA_W-1:0] left_y;
    logic signed [DATA_W-1:0] right_x;
    logic signed [DATA_W-1:0] right_y;
    logic signed [DATA_W-1:0] wheel_speed;
  } approach_word_t;

  typedef struct {
    logic [ACT_W-1:0]         action;
    logic signed [DATA_W-1:0] left_drive;
    logic signed [DATA_W-1:0] right_drive;
    logic                     lights_on;
    logic                     done_res;
  } drive_word_t;

  // one line of the directed table: a register write or an input word
  typedef struct {
    bit                    is_cfg;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_data;
    approach_word_t        w;
    bit                    pinned;
    drive_word_t           exp;
  } plan_row_t;

  logic clk;
  logic rst_n;

  vtas_in_if  in_if();
  vtas_out_if out_if();
  vtas_cfg_if cfg_if();

  vision_target_approach_steering u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // predictor copy of registers and approach state
  logic                  tape_mode  = 1'b0;
  logic [MS_W-1:0]       lost_ms    = LOST_TIMEOUT_RST;
  logic [MS_W-1:0]       coast_ms   = COAST_TIME_RST;
  logic [PHASE_W-1:0]    appr_phase = PH_IDLE;
  logic [TIME_W-1:0]     phase_t0   = '0;
  logic                  done_flag  = 1'b0;
  logic                  lights     = 1'b0;

  drive_word_t drive_expect_q[$];
  plan_row_t   plan_q[$];

  int  n_fail    = 0;
  int  n_cycles  = 0;
  int  burst_left = 0;
  bit  gaps_on   = 1'b1;
  int  rx_mode   = 2;
  logic [15:0] rx_pattern = 16'hF0F3;
  logic [3:0]  rx_idx = '0;
  bit  hold_req  = 1'b0;
  int  hold_left = 0;

  // pinned expectation travels with the word being offered
  bit          cur_pinned = 1'b0;
  drive_word_t cur_pin_res;

  // Works out the result of one word and advances the approach state
  function automatic drive_word_t steer_predict(approach_word_t w);
    logic [TIME_W-1:0] elapsed;
    longint lx, ly, rx, ry, wh, x, y, v1, v2, vb, ax, ld, rd;
    logic [ACT_W-1:0] act;
    bit near;
    drive_word_t r;
    elapsed = w.now_ms - phase_t0;
    lx = w.left_x;
    ly = w.left_y;
    rx = w.right_x;
    ry = w.right_y;
    wh = w.wheel_speed;
    act = ACT_NONE;
    ld = 0;
    rd = 0;
    case (w.kind)
      KIND_START: begin
        appr_phase = PH_MOVE;
        phase_t0 = w.now_ms;
        if (tape_mode) lights = 1'b1;
        done_flag = 1'b0;
        act = ACT_STOP;
      end
      KIND_END: begin
        lights = 1'b0;
        act = ACT_STOP;
      end
      KIND_TICK: begin
        if (appr_phase == PH_IDLE || (!w.left_seen && !w.right_seen)) begin
          // target lost or nothing to do
          if (elapsed > TIME_W'(lost_ms)) done_flag = 1'b1;
          act = ACT_STOP;
        end else begin
          // fuse cameras
          if (w.left_seen && w.right_seen) begin
            x = (lx + rx) >>> 1;
            y = (ly + ry) >>> 1;
          end else if (w.left_seen) begin
            x = lx - C_CAM_SHIFT;
            y = ly;
          end else begin
            x = rx + C_CAM_SHIFT;
            y = ry;
          end
          if (appr_phase == PH_COAST && elapsed > TIME_W'(coast_ms)) begin
            appr_phase = PH_IDLE;
            phase_t0 = w.now_ms;
            done_flag = 1'b1;
            act = ACT_STOP;
          end else if (appr_phase == PH_MOVE) begin
            if (!tape_mode) near = (y < -C_CUBE_NEAR);
            else if (w.left_seen && w.right_seen)
              near = (((rx - lx) < 0) ? (lx - rx) : (rx - lx)) > C_HALF;
            else near = (y < -C_HALF);
            act = ACT_DRIVE;
            if (near) begin
              appr_phase = PH_COAST;
              phase_t0 = w.now_ms;
              ld = -C_CREEP;
              rd = -C_CREEP;
            end else begin
              // steering: proportional term plus wheel-scaled term
              ax = (x < 0) ? -x : x;
              v1 = (x * C_GAIN_X) >>> FRAC;
              v2 = (((C_GAIN_W * wh) >>> FRAC) * ax) >>> FRAC;
              vb = v1 + v2;
              if ((v1 > 0 && vb < 0) || (v1 < 0 && vb > 0)) vb = 0;
              if (vb > C_VB_MAX) vb = C_VB_MAX;
              else if (vb < -C_VB_MAX) vb = -C_VB_MAX;
              // always within 16-bit range
              ld = -C_CREEP - vb;
              rd = -C_CREEP + vb;
            end
          end
        end
      end
      default: ;
    endcase
    r.action = act;
    r.left_drive = DATA_W'(ld);
    r.right_drive = DATA_W'(rd);
    r.lights_on = lights;
    r.done_res = done_flag;
    return r;
  endfunction

  // directed table helpers
  function automatic void add_row(logic [KIND_W-1:0] k, logic [TIME_W-1:0] t, bit ls,
                                  bit rs, int lx, int ly, int rx, int ry, int wh);
    plan_row_t p;
    p.is_cfg = 1'b0;
    p.cfg_addr = '0;
    p.cfg_data = '0;
    p.w.kind = k;
    p.w.now_ms = t;
    p.w.left_seen = ls;
    p.w.right_seen = rs;
    p.w.left_x = DATA_W'(lx);
    p.w.left_y = DATA_W'(ly);
    p.w.right_x = DATA_W'(rx);
    p.w.right_y = DATA_W'(ry);
    p.w.wheel_speed = DATA_W'(wh);
    p.pinned = 1'b0;
    p.exp = '{default: '0};
    plan_q.push_back(p);
  endfunction

  function automatic void pin(logic [ACT_W-1:0] a, int ld, int rd, bit li, bit dn);
    int i;
    i = plan_q.size() - 1;
    plan_q[i].pinned = 1'b1;
    plan_q[i].exp.action = a;
    plan_q[i].exp.left_drive = DATA_W'(ld);
    plan_q[i].exp.right_drive = DATA_W'(rd);
    plan_q[i].exp.lights_on = li;
    plan_q[i].exp.done_res = dn;
  endfunction

  function automatic void add_cfg(logic [CFG_ADDR_W-1:0] a, logic [CFG_DATA_W-1:0] d);
    plan_row_t p;
    p = '{default: '0};
    p.is_cfg = 1'b1;
    p.cfg_addr = a;
    p.cfg_data = d;
    plan_q.push_back(p);
  endfunction

  // Offers one word, with burst gaps ahead of it, and waits for it to be taken
  task automatic send_word(approach_word_t w, bit pinned, drive_word_t pr);
    int gap;
    if (burst_left == 0) begin
      gap = (gaps_on && $urandom_range(0, 2) != 0) ? $urandom_range(1, 8) : 0;
      burst_left = $urandom_range(1, 16);
      repeat (gap) begin
        @(negedge clk);
        in_if.valid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    in_if.kind        <= w.kind;
    in_if.now_ms      <= w.now_ms;
    in_if.left_seen   <= w.left_seen;
    in_if.right_seen  <= w.right_seen;
    in_if.left_x      <= w.left_x;
    in_if.left_y      <= w.left_y;
    in_if.right_x     <= w.right_x;
    in_if.right_y     <= w.right_y;
    in_if.wheel_speed <= w.wheel_speed;
    in_if.valid       <= 1'b1;
    cur_pinned  = pinned;
    cur_pin_res = pr;
    do @(posedge clk); while (!in_if.ready);
  endtask

  // Stops offering and waits until every expected word has come out
  task automatic settle();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (drive_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] a, logic [CFG_DATA_W-1:0] d);
    @(negedge clk);
    cfg_if.addr  <= a;
    cfg_if.data  <= d;
    cfg_if.valid <= 1'b1;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Random control tick with plausible camera data
  function automatic approach_word_t make_tick(logic [TIME_W-1:0] t);
    approach_word_t w;
    int r, c, d;
    r = $urandom_range(0, 9);
    w.kind = KIND_TICK;
    w.now_ms = t;
    w.left_seen = (r == 1 || r == 2 || r >= 5);
    w.right_seen = (r >= 3);
    c = int'($urandom_range(0, 16000)) - 8000;
    d = int'($urandom_range(0, 9000)) - 4500;
    w.left_x = DATA_W'(c - d);
    w.right_x = DATA_W'(c + d);
    // mostly far away, sometimes near the close-enough thresholds
    if ($urandom_range(0, 3) == 0) c = int'($urandom_range(0, 8000)) - 16000;
    else c = int'($urandom_range(0, 40000)) - 8000;
    w.left_y = DATA_W'(c + int'($urandom_range(0, 600)) - 300);
    w.right_y = DATA_W'(c + int'($urandom_range(0, 600)) - 300);
    if ($urandom_range(0, 1) != 0) w.wheel_speed = DATA_W'($urandom);
    else w.wheel_speed = DATA_W'(int'($urandom_range(0, 16000)) - 8000);
    return w;
  endfunction

  // capture accepted input words into the predictor
  always @(posedge clk) begin : in_mon
    approach_word_t aw;
    drive_word_t    pr;
    if (rst_n && in_if.valid && in_if.ready) begin
      aw.kind        = in_if.kind;
      aw.now_ms      = in_if.now_ms;
      aw.left_seen   = in_if.left_seen;
      aw.right_seen  = in_if.right_seen;
      aw.left_x      = in_if.left_x;
      aw.left_y      = in_if.left_y;
      aw.right_x     = in_if.right_x;
      aw.right_y     = in_if.right_y;
      aw.wheel_speed = in_if.wheel_speed;
      pr = steer_predict(aw);
      drive_expect_q.push_back(cur_pinned ? cur_pin_res : pr);
    end
  end

  // register writes update the predictor copy
  always @(posedge clk) begin
    if (rst_n && cfg_if.valid && cfg_if.ready) begin
      case (cfg_if.addr)
        CFG_TAPE:  tape_mode = cfg_if.data[0];
        CFG_LOST:  lost_ms   = cfg_if.data;
        CFG_COAST: coast_ms  = cfg_if.data;
        default: ;
      endcase
    end
  end

  // compare each result word with the oldest expectation
  always @(posedge clk) begin : out_mon
    drive_word_t e;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (drive_expect_q.size() == 0) begin
        $error("result word with no expectation waiting");
        n_fail++;
      end else begin
        e = drive_expect_q.pop_front();
        if (out_if.drive_action !== e.action) begin
          $error("drive_action: expected %0d, got %0d", e.action, out_if.drive_action);
          n_fail++;
        end
        if (out_if.left_drive !== e.left_drive) begin
          $error("left_drive: expected %0d, got %0d", e.left_drive, out_if.left_drive);
          n_fail++;
        end
        if (out_if.right_drive !== e.right_drive) begin
          $error("right_drive: expected %0d, got %0d", e.right_drive, out_if.right_drive);
          n_fail++;
        end
        if (out_if.lights_on !== e.lights_on) begin
          $error("lights_on: expected %0d, got %0d", e.lights_on, out_if.lights_on);
          n_fail++;
        end
        if (out_if.done_res !== e.done_res) begin
          $error("done_res: expected %0d, got %0d", e.done_res, out_if.done_res);
          n_fail++;
        end
      end
    end
  end

  // receiver: long hold-off on request, else its own stall pattern
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= rx_pattern[rx_idx];
        default: out_if.ready <= ($urandom_range(0, 3) != 0);
      endcase
      rx_idx <= rx_idx + 4'd1;
    end
  end

  // run limit
  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : stim
    approach_word_t w;
    drive_word_t    none_res;
    logic [TIME_W-1:0] t_now;
    int n, r, ph;
    logic [MS_W-1:0] lost_v, coast_v;

    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.kind = KIND_START;
    in_if.now_ms = '0;
    in_if.left_seen = 1'b0;
    in_if.right_seen = 1'b0;
    in_if.left_x = '0;
    in_if.left_y = '0;
    in_if.right_x = '0;
    in_if.right_y = '0;
    in_if.wheel_speed = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.addr = CFG_TAPE;
    cfg_if.data = '0;
    none_res = '{default: '0};

    // directed table, cube target, reset timeouts
    add_row(KIND_TICK, 0, 1, 1, 0, 0, 0, 0, 0);                 // idle tick
    pin(ACT_STOP, 0, 0, 0, 0);
    add_row(KIND_TICK, 1001, 0, 0, 0, 0, 0, 0, 0);              // idle past lost timeout
    pin(ACT_STOP, 0, 0, 0, 1);
    add_row(KIND_SPARE, 0, 1, 1, 100, 100, 100, 100, 100);      // ignored kind
    pin(ACT_NONE, 0, 0, 0, 1);
    add_row(KIND_START, 2000, 0, 0, 0, 0, 0, 0, 0);
    pin(ACT_STOP, 0, 0, 0, 0);
    add_row(KIND_TICK, 2010, 1, 1, 0, 0, 0, 0, 0);              // centered, straight
    pin(ACT_DRIVE, -3277, -3277, 0, 0);
    add_row(KIND_TICK, 2020, 1, 1, 32767, 32767, 32767, 32767, 32767);
    pin(ACT_DRIVE, -6062, -492, 0, 0);
    add_row(KIND_TICK, 2030, 1, 1, -32768, 32767, -32768, 32767, -32768);
    pin(ACT_DRIVE, -492, -6062, 0, 0);
    add_row(KIND_TICK, 2040, 1, 1, 3, 0, 3, 0, -32768);         // sign flip forces zero
    pin(ACT_DRIVE, -3277, -3277, 0, 0);
    add_row(KIND_TICK, 2050, 1, 1, -3, 0, -3, 0, 32767);
    add_row(KIND_TICK, 2060, 1, 0, 0, 0, 0, 0, 0);              // left camera only
    add_row(KIND_TICK, 2070, 0, 1, -32768, 0, -32768, 0, 1234); // right camera only
    add_row(KIND_TICK, 2080, 1, 1, 0, -13926, 0, -13926, 0);    // just not close
    add_row(KIND_TICK, 2100, 1, 1, 0, -13927, 0, -13927, 0);    // cube close: coast
    pin(ACT_DRIVE, -3277, -3277, 0, 0);
    add_row(KIND_TICK, 2600, 1, 1, 0, 0, 0, 0, 0);              // coast still running
    pin(ACT_NONE, 0, 0, 0, 0);
    add_row(KIND_TICK, 2601, 0, 0, 0, 0, 0, 0, 0);              // lost while coasting
    pin(ACT_STOP, 0, 0, 0, 0);
    add_row(KIND_TICK, 2601, 1, 1, 0, 0, 0, 0, 0);              // coast expired
    pin(ACT_STOP, 0, 0, 0, 1);
    add_row(KIND_END, 2700, 0, 0, 0, 0, 0, 0, 0);
    pin(ACT_STOP, 0, 0, 0, 1);
    add_row(KIND_START, 32'hFFFF_FFF0, 0, 0, 0, 0, 0, 0, 0);    // time wraps next
    pin(ACT_STOP, 0, 0, 0, 0);
    add_row(KIND_TICK, 32'h0000_0010, 0, 0, 0, 0, 0, 0, 0);
    pin(ACT_STOP, 0, 0, 0, 0);
    add_row(KIND_TICK, 1008, 0, 0, 0, 0, 0, 0, 0);
    pin(ACT_STOP, 0, 0, 0, 1);
    // tape target with lights
    add_cfg(CFG_TAPE, 16'd1);
    add_row(KIND_START, 5000, 0, 0, 0, 0, 0, 0, 0);
    pin(ACT_STOP, 0, 0, 1, 0);
    add_row(KIND_TICK, 5010, 1, 1, -4096, 0, 4096, 0, 0);       // spread just not close
    add_row(KIND_TICK, 5020, 1, 1, -4096, 0, 4097, 0, 0);       // spread close: coast
    pin(ACT_DRIVE, -3277, -3277, 1, 0);
    add_row(KIND_START, 6000, 0, 0, 0, 0, 0, 0, 0);
    pin(ACT_STOP, 0, 0, 1, 0);
    add_row(KIND_TICK, 6010, 1, 0, 0, -8193, 0, 0, 0);          // one camera close
    pin(ACT_DRIVE, -3277, -3277, 1, 0);
    add_row(KIND_END, 6020, 0, 0, 0, 0, 0, 0, 0);
    pin(ACT_STOP, 0, 0, 0, 0);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // walk the directed table
    foreach (plan_q[i]) begin
      if (plan_q[i].is_cfg) begin
        settle();
        write_reg(plan_q[i].cfg_addr, plan_q[i].cfg_data);
      end else begin
        send_word(plan_q[i].w, plan_q[i].pinned, plan_q[i].exp);
      end
    end

    // random phases, each with its own settings and idling
    t_now = 32'd10000;
    for (ph = 0; ph < N_PHASES; ph++) begin
      settle();
      case (ph)
        0: begin lost_v = 16'd0;     coast_v = 16'd0;     end
        1: begin lost_v = 16'hFFFF;  coast_v = 16'hFFFF;  end
        default: begin
          r = $urandom_range(0, 3);
          lost_v = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF : MS_W'($urandom_range(0, 2500));
          r = $urandom_range(0, 3);
          coast_v = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF : MS_W'($urandom_range(0, 2000));
        end
      endcase
      write_reg(CFG_TAPE, CFG_DATA_W'(ph % 2));
      write_reg(CFG_LOST, lost_v);
      write_reg(CFG_COAST, coast_v);
      if (ph == 5) t_now = 32'hFFFF_FF00;
      gaps_on = (ph % 4 != 2);
      rx_mode = (ph % 4 == 2) ? 0 : $urandom_range(1, 2);
      rx_pattern = 16'($urandom) | 16'h0101;
      if (ph == 3) hold_req = 1'b1;
      n = 0;
      while (n < PHASE_WORDS) begin
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 29) == 0) t_now += $urandom_range(400, 3000);
        else t_now += $urandom_range(0, 60);
        if (r < 6) begin
          w = make_tick(t_now);
          w.kind = KIND_START;
        end else if (r < 10) begin
          w = make_tick(t_now);
          w.kind = KIND_END;
        end else if (r < 12) begin
          w = make_tick(t_now);
          w.kind = KIND_SPARE;
        end else if (r < 17) begin
          // noise: every field random
          w.kind = KIND_W'($urandom_range(0, 3));
          w.now_ms = $urandom;
          w.left_seen = $urandom_range(0, 1);
          w.right_seen = $urandom_range(0, 1);
          w.left_x = DATA_W'($urandom);
          w.left_y = DATA_W'($urandom);
          w.right_x = DATA_W'($urandom);
          w.right_y = DATA_W'($urandom);
          w.wheel_speed = DATA_W'($urandom);
        end else begin
          w = make_tick(t_now);
        end
        send_word(w, 1'b0, none_res);
        if (w.kind != KIND_SPARE) n++;
      end
    end

    settle();
    if (n_fail == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+src
src/vtas_pkg.sv
src/vtas_in_if.sv
src/vtas_out_if.sv
src/vtas_cfg_if.sv
src/vtas_ctrl.sv
src/vtas_dp.sv
src/vision_target_approach_steering.sv
src/vtas_checker.sv
test/tb_vision_target_approach_steering.sv
